@@ sv/dps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared sizes, codes and types of the dynamic priority scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_RUN = 1'b1;

  localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

  typedef struct packed {
    logic        [31:0] tag;
    logic        [15:0] svc_time;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic               accepted;
    logic        [31:0] chosen_tag;
    logic        [15:0] time_left;
    logic signed [15:0] priority_after;
    logic               finished;
    logic               table_empty;
    logic               table_full;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

@@ sv/dps_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_in_if
// Request channel: one word per add or run command.
// ----------------------------------------------------------------------------
interface dps_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic        [31:0] task_tag;
  logic        [15:0] service_time;
  logic signed [15:0] start_priority;

  modport source (output valid, action, task_tag, service_time, start_priority,
                  input ready);
  modport sink   (input valid, action, task_tag, service_time, start_priority,
                  output ready);
endinterface

@@ sv/dps_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_out_if
// Result channel: one word per accepted command.
// ----------------------------------------------------------------------------
interface dps_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic        [31:0] chosen_tag;
  logic        [15:0] time_left;
  logic signed [15:0] priority_after;
  logic               finished;
  logic               table_empty;
  logic               table_full;

  modport source (output valid, accepted, chosen_tag, time_left, priority_after,
                  finished, table_empty, table_full, input ready);
  modport sink   (input valid, accepted, chosen_tag, time_left, priority_after,
                  finished, table_empty, table_full, output ready);
endinterface

@@ sv/dps_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dps_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_seq
// Sequencer and shared compare/shift datapath over the circular task table.
// ----------------------------------------------------------------------------
module dps_seq import dps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               action,
  input  logic        [31:0] task_tag,
  input  logic        [15:0] service_time,
  input  logic signed [15:0] start_priority,
  input  logic               out_free,
  output logic               idle,
  output logic               done,
  output result_t            res,
  output ram_wr_t            ram_wr,
  output logic [IDX_W-1:0]   ram_raddr,
  input  entry_t             ram_rdata
);

  state_t state, state_next;

  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;

  entry_t cur, cur_next;

  logic               res_acc, res_acc_next;
  logic        [31:0] res_tag, res_tag_next;
  logic        [15:0] res_time, res_time_next;
  logic signed [15:0] res_prio, res_prio_next;
  logic               res_fin, res_fin_next;

  logic               add_ok;
  logic [IDX_W-1:0]   head_inc;
  logic [CNT_W-1:0]   count_dec;
  logic        [15:0] time_dec;
  logic signed [15:0] prio_dec;
  logic               shift_down;

  // Map a logical position to a physical slot of the circular table.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(k);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  assign add_ok     = (service_time != 16'd0) && (count != CAP_CNT);
  assign head_inc   = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + 1'b1;
  assign count_dec  = count - 1'b1;
  assign time_dec   = (ram_rdata.svc_time != 16'd0) ? ram_rdata.svc_time - 16'd1
                                                     : ram_rdata.svc_time;
  assign prio_dec   = (ram_rdata.prio != PRIO_MIN) ? ram_rdata.prio - 16'sd1
                                                   : ram_rdata.prio;
  assign shift_down = (ram_rdata.prio <= cur.prio);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_ADD) begin
            if (!add_ok) begin
              state_next = S_DONE;
            end else if (count == '0) begin
              state_next = S_PLACE;
            end else begin
              state_next = S_SCAN;
            end
          end else begin
            state_next = (count == '0) ? S_DONE : S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (time_dec == 16'd0) begin
          state_next = S_DONE;
        end else if (count_dec == '0) begin
          state_next = S_PLACE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!shift_down) begin
          state_next = S_DONE;
        end else if (idx == '0) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and table access
  always_comb begin
    head_next     = head;
    count_next    = count;
    idx_next      = idx;
    cur_next      = cur;
    res_acc_next  = res_acc;
    res_tag_next  = res_tag;
    res_time_next = res_time;
    res_prio_next = res_prio;
    res_fin_next  = res_fin;
    ram_raddr     = slot(head, '0);
    ram_wr.en     = 1'b0;
    ram_wr.addr   = slot(head, idx + 1'b1);
    ram_wr.data   = cur;
    case (state)
      S_IDLE: begin
        if (start) begin
          cur_next.tag      = task_tag;
          cur_next.svc_time = service_time;
          cur_next.prio     = start_priority;
          res_acc_next      = 1'b0;
          res_tag_next      = '0;
          res_time_next     = '0;
          res_prio_next     = '0;
          res_fin_next      = 1'b0;
          if (action == ACT_ADD) begin
            res_acc_next = add_ok;
            idx_next     = count_dec;
            ram_raddr    = slot(head, count_dec);
          end
        end
      end
      S_HEAD: begin
        // Pop the head, age it, and seed the reinsertion scan.
        head_next         = head_inc;
        count_next        = count_dec;
        res_acc_next      = 1'b1;
        res_tag_next      = ram_rdata.tag;
        res_time_next     = time_dec;
        res_prio_next     = prio_dec;
        res_fin_next      = (time_dec == 16'd0);
        cur_next.tag      = ram_rdata.tag;
        cur_next.svc_time = time_dec;
        cur_next.prio     = prio_dec;
        idx_next          = count_dec - 1'b1;
        ram_raddr         = slot(head_inc, count_dec - 1'b1);
      end
      S_SCAN: begin
        ram_wr.en = 1'b1;
        if (shift_down) begin
          ram_wr.data = ram_rdata;
          idx_next    = idx - 1'b1;
          ram_raddr   = slot(head, idx - 1'b1);
        end else begin
          count_next = count + 1'b1;
        end
      end
      S_PLACE: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = slot(head, '0);
        count_next  = count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cur      <= cur_next;
    res_acc  <= res_acc_next;
    res_tag  <= res_tag_next;
    res_time <= res_time_next;
    res_prio <= res_prio_next;
    res_fin  <= res_fin_next;
  end

  assign idle                = (state == S_IDLE);
  assign done                = (state == S_DONE);
  assign res.accepted        = res_acc;
  assign res.chosen_tag      = res_tag;
  assign res.time_left       = res_time;
  assign res.priority_after  = res_prio;
  assign res.finished        = res_fin;
  assign res.table_empty     = (count == '0);
  assign res.table_full      = (count == CAP_CNT);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("task count exceeds capacity");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> idx < count)
    else $error("scan index outside the table");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("command started while busy");

  a_reject_keeps_table: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !res_acc |-> count == $past(count))
    else $error("rejected command changed the table");

  a_write_only_when_placing: assert property (@(posedge clk) disable iff (rst)
    ram_wr.en |-> (state == S_SCAN || state == S_PLACE))
    else $error("table write outside insertion");

endmodule

@@ sv/dynamic_priority_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler
// Priority scheduler with aging over a sorted 16-entry task table.
// ----------------------------------------------------------------------------
// Sequence after a command is accepted: a rejected add or a run on an empty
//   table goes straight to S_DONE; a run whose task finishes passes S_HEAD
//   only; an add goes through the insertion (S_SCAN and/or S_PLACE), and any
//   other run passes S_HEAD and then the insertion. The scan moves n
//   (0..CAPACITY-1) entries down, one entry per cycle through the table
//   RAM port. Commands are handled one at a time: no new command is taken
//   until the result word is loaded into the output register.
// Reset (rst, synchronous): empties the table and drops any pending result;
//   the table RAM itself is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler import dps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dps_in_if.sink    in_ch,
  dps_out_if.source out_ch
);

  // The table lives in a circular RAM: head pointer plus count. A run pops the
  // head by advancing the pointer; an insertion walks from the tail toward the
  // head, moving every entry with priority not above the new one down a slot,
  // so equal priorities end up behind the newest task.

  logic    seq_idle;
  logic    seq_done;
  logic    out_free;
  logic    start;
  result_t seq_res;
  ram_wr_t ram_wr;
  logic [IDX_W-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;

  // Output register: hold a finished word until the sink takes it.
  logic    out_valid;
  result_t out_res;

  assign start        = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = seq_idle;
  assign out_free     = !out_valid || out_ch.ready;

  dps_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .action         (in_ch.action),
    .task_tag       (in_ch.task_tag),
    .service_time   (in_ch.service_time),
    .start_priority (in_ch.start_priority),
    .out_free       (out_free),
    .idle           (seq_idle),
    .done           (seq_done),
    .res            (seq_res),
    .ram_wr         (ram_wr),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (entry_t'(ram_rdata))
  );

  dps_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load a new word when the sequencer finishes and the slot is free; drop
  // the valid flag once the sink takes the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done && out_free) begin
      out_res <= seq_res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.accepted       = out_res.accepted;
  assign out_ch.chosen_tag     = out_res.chosen_tag;
  assign out_ch.time_left      = out_res.time_left;
  assign out_ch.priority_after = out_res.priority_after;
  assign out_ch.finished       = out_res.finished;
  assign out_ch.table_empty    = out_res.table_empty;
  assign out_ch.table_full     = out_res.table_full;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dynamic priority scheduler.
// A predictor keeps its own sorted copy of the task table. Each command word
// accepted on the request channel is scored against it, and each result word
// is compared field by field with the oldest prediction. The named tests
// cover the edge cases first (empty table, zero time, full table, priority
// floor, equal-priority ordering). Random scheduling traffic and a long
// result-side stall follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb import dps_pkg::*; ();

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_CYCLES = 400;
  localparam int RANDOM_WORDS = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dps_in_if  in_ch ();
  dps_out_if out_ch ();

  dynamic_priority_scheduler dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Predicted task table, head at entry 0, kept sorted like the block's own.
  logic        [31:0] model_tag  [CAPACITY];
  logic        [15:0] model_time [CAPACITY];
  logic signed [15:0] model_prio [CAPACITY];
  int                 model_count = 0;

  // Results predicted for accepted commands, oldest first.
  result_t slice_reports[$];
  result_t due_word;

  int  err_count = 0;
  int  cycle_count = 0;
  bit  idle_en = 1'b1;
  bit  holding = 1'b0;
  event hold_go;

  // Coverage tallies for the closing summary.
  int n_stored = 0;
  int n_rejected = 0;
  int n_slices = 0;
  int n_finished = 0;
  int n_empty_runs = 0;
  int n_full_hits = 0;
  int n_empty_hits = 0;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Insert ahead of the first entry whose priority is not greater, so the
  // newest task wins among equal priorities. The caller guarantees room.
  function automatic void place_task(input logic [31:0] tag, input logic [15:0] tm,
                                     input logic signed [15:0] pr);
    int pos;
    pos = 0;
    while (pos < model_count && pr < model_prio[pos]) pos++;
    for (int i = model_count; i > pos; i--) begin
      model_tag[i]  = model_tag[i-1];
      model_time[i] = model_time[i-1];
      model_prio[i] = model_prio[i-1];
    end
    model_tag[pos]  = tag;
    model_time[pos] = tm;
    model_prio[pos] = pr;
    model_count++;
  endfunction

  // Apply one command to the predicted table and return the result word.
  function automatic result_t schedule_command(input logic act, input logic [31:0] tag,
                                               input logic [15:0] tm,
                                               input logic signed [15:0] pr);
    result_t            r;
    logic        [31:0] head_tag;
    logic        [15:0] head_time;
    logic signed [15:0] head_prio;
    r = '0;
    if (act == ACT_ADD) begin
      if (tm != 16'd0 && model_count < CAPACITY) begin
        place_task(tag, tm, pr);
        r.accepted = 1'b1;
        n_stored++;
      end else begin
        n_rejected++;
      end
    end else if (model_count > 0) begin
      head_tag  = model_tag[0];
      head_time = model_time[0];
      head_prio = model_prio[0];
      // Pop the head; the rest of the table moves up one place.
      for (int i = 1; i < model_count; i++) begin
        model_tag[i-1]  = model_tag[i];
        model_time[i-1] = model_time[i];
        model_prio[i-1] = model_prio[i];
      end
      model_count--;
      if (head_time != 16'd0) head_time = head_time - 16'd1;
      // Aging: drop the priority by one, holding at the floor.
      if (head_prio != PRIO_MIN) head_prio = head_prio - 16'sd1;
      r.accepted       = 1'b1;
      r.chosen_tag     = head_tag;
      r.time_left      = head_time;
      r.priority_after = head_prio;
      n_slices++;
      if (head_time != 16'd0) begin
        place_task(head_tag, head_time, head_prio);
      end else begin
        r.finished = 1'b1;
        n_finished++;
      end
    end else begin
      n_empty_runs++;
    end
    r.table_empty = (model_count == 0);
    r.table_full  = (model_count >= CAPACITY);
    if (r.table_full) n_full_hits++;
    if (r.table_empty) n_empty_hits++;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------

  // Offer one command word; drive at the falling edge, score it at the rising
  // edge where it is taken. Valid stays high into the next call, which either
  // replaces the word or drops valid for an idle gap.
  task automatic send_command(input logic act, input logic [31:0] tag,
                              input logic [15:0] tm, input logic signed [15:0] pr);
    @(negedge clk);
    if (idle_en && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.task_tag       <= tag;
    in_ch.service_time   <= tm;
    in_ch.start_priority <= pr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    slice_reports.push_back(schedule_command(act, tag, tm, pr));
  endtask

  task automatic send_run();
    // Fields other than the action are ignored on a run; fill them with noise.
    send_command(ACT_RUN, $urandom, 16'($urandom), 16'($urandom));
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (slice_reports.size() != 0) @(posedge clk);
  endtask

  task automatic drain_table();
    while (model_count > 0) send_run();
  endtask

  // One well-formed random command. add_pct steers the mix toward filling or
  // emptying the table; at the edges it is overridden so both extremes recur.
  task automatic random_command(input int add_pct);
    int                 pick;
    logic        [15:0] tm;
    logic signed [15:0] pr;
    if (model_count == 0) add_pct = 90;
    else if (model_count >= CAPACITY) add_pct = 35;
    if ($urandom_range(99) < add_pct) begin
      // A full table rejects anything, so spend the wide times there; stored
      // tasks keep short times so the table keeps turning over.
      if (model_count >= CAPACITY) tm = 16'($urandom);
      else if ($urandom_range(99) < 8) tm = 16'd0;
      else tm = 16'($urandom_range(5, 1));
      pick = $urandom_range(99);
      if (pick < 50) begin
        pr = 16'($urandom);
      end else if (pick < 85) begin
        pr = 16'(int'($urandom_range(6)) - 3);  // narrow band to force ties
      end else begin
        case ($urandom_range(2))
          0:       pr = PRIO_MIN;
          1:       pr = PRIO_MIN + 16'sd1;
          default: pr = 16'sh7fff;
        endcase
      end
      send_command(ACT_ADD, $urandom, tm, pr);
    end else begin
      send_run();
    end
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  // Ready changes at the falling edge: low for the whole long stall, else
  // low with a chance of 13 in a hundred at each falling edge while idling is enabled.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (holding) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_en && $urandom_range(99) < 13);
    end
  end

  // Long receiver stall, counted here so the sender runs on meanwhile.
  always begin
    @(hold_go);
    holding = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  task automatic check_field(input string field, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      err_count++;
    end
  endtask

  // Score each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (slice_reports.size() == 0) begin
        $error("result word with no command pending: tag %h", out_ch.chosen_tag);
        err_count++;
      end else begin
        due_word = slice_reports.pop_front();
        check_field("accepted", $signed({1'b0, due_word.accepted}),
                    $signed({1'b0, out_ch.accepted}));
        check_field("chosen_tag", $signed({1'b0, due_word.chosen_tag}),
                    $signed({1'b0, out_ch.chosen_tag}));
        check_field("time_left", $signed({1'b0, due_word.time_left}),
                    $signed({1'b0, out_ch.time_left}));
        check_field("priority_after", due_word.priority_after, out_ch.priority_after);
        check_field("finished", $signed({1'b0, due_word.finished}),
                    $signed({1'b0, out_ch.finished}));
        check_field("table_empty", $signed({1'b0, due_word.table_empty}),
                    $signed({1'b0, out_ch.table_empty}));
        check_field("table_full", $signed({1'b0, due_word.table_full}),
                    $signed({1'b0, out_ch.table_full}));
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, slice_reports.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Empty-table run, zero-time add, extreme tags and priorities, equal
  // priorities ordered newest first, and a task finishing.
  task automatic test_directed_basics();
    send_run();
    send_command(ACT_ADD, 32'h1234_5678, 16'd0, 16'sd9);
    send_command(ACT_ADD, 32'hffff_ffff, 16'd2, 16'sh7fff);
    send_command(ACT_ADD, 32'h0000_0000, 16'd1, PRIO_MIN);
    send_command(ACT_ADD, 32'h1111_1111, 16'd3, 16'sd0);
    send_command(ACT_ADD, 32'h2222_2222, 16'd3, 16'sd0);
    send_run();  // top task ages to 32766, stays at head
    send_run();  // top task finishes
    send_run();  // newest of the tied pair goes first
    send_run();
    wait_results();
  endtask

  // Fill to capacity, bounce adds off the full table, free a slot, refill.
  task automatic test_full_table();
    int k;
    k = 0;
    while (model_count < CAPACITY) begin
      send_command(ACT_ADD, 32'h1000_0000 + k, 16'd1, 16'(k * 7 - 40));
      k++;
    end
    send_command(ACT_ADD, 32'h8000_0001, 16'hffff, 16'sd0);
    send_run();
    send_command(ACT_ADD, 32'h7fff_fffe, 16'd1, 16'sd3);
    send_command(ACT_ADD, 32'h5555_aaaa, 16'h8000, 16'sh7fff);
    drain_table();
    wait_results();
  endtask

  // Priority floor: one step onto the minimum, then a run that holds there.
  task automatic test_priority_floor();
    send_command(ACT_ADD, 32'h5a5a_5a5a, 16'd2, PRIO_MIN);
    send_command(ACT_ADD, 32'ha5a5_a5a5, 16'd1, PRIO_MIN + 16'sd1);
    send_run();
    send_run();
    send_run();
    send_run();  // empty again
    wait_results();
  endtask

  // Stall the result side while commands keep coming, so the block backs up
  // and holds off its input; then pause the sender until all results are in.
  task automatic test_backpressure();
    ->hold_go;
    repeat (40) random_command(60);
    wait_results();
  endtask

  // Random traffic in alternating fill and drain phases; the middle stretch
  // runs with no idling on either side.
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      idle_en = !(i >= count / 2 && i < count / 2 + 200);
      random_command(((i / 24) % 2 == 0) ? 70 : 30);
    end
    idle_en = 1'b1;
    wait_results();
  endtask

  // Long service times, stored and aged; both tasks stay resident.
  task automatic test_long_service();
    drain_table();
    send_command(ACT_ADD, 32'hc3c3_c3c3, 16'hffff, 16'sh7fff);
    send_command(ACT_ADD, 32'h3c3c_3c3c, 16'h8000, 16'sh7fff);
    send_run();
    send_run();
    send_run();
    wait_results();
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_ADD;
    in_ch.task_tag       = '0;
    in_ch.service_time   = '0;
    in_ch.start_priority = '0;
    out_ch.ready         = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_full_table();
    test_priority_floor();
    test_backpressure();
    test_random_mix(RANDOM_WORDS);
    test_long_service();

    // Let any stray result word show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d adds stored, %0d rejected, %0d slices run (%0d finished)",
             n_stored, n_rejected, n_slices, n_finished);
    $display("%0d runs on empty; table seen full %0d times, empty %0d; %0d mismatches",
             n_empty_runs, n_full_hits, n_empty_hits, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
